// ===== src/ebdpd_pkg.sv =====
// shared types, constants and register indexes for the dual pwm drive block
// no dependencies; used by the channel interfaces, the step logic and the top level
package ebdpd_pkg;

    localparam int COUNT_BITS = 32;
    localparam int FIELD_BITS = 32;
    localparam int DUTY_BITS  = 7;
    localparam int STEP_BITS  = 6;
    localparam int TOL_BITS   = 8;
    localparam int BIAS_BITS  = 16;
    localparam int Q_FRAC     = 15;
    localparam int PROD_BITS  = COUNT_BITS + BIAS_BITS;
    localparam int CMP_BITS   = PROD_BITS + 1;
    localparam int CFG_BITS   = 8;
    localparam int IDX_BITS   = 2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [IDX_BITS-1:0] REG_PWM_PERIOD      = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_DUTY_STEP       = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_MATCH_TOLERANCE = 2'd2;

    localparam logic [DUTY_BITS-1:0] PERIOD_RESET    = 7'd100;
    localparam logic [STEP_BITS-1:0] DUTY_STEP_RESET = 6'd3;
    localparam logic [TOL_BITS-1:0]  TOLERANCE_RESET = 8'd0;

    typedef struct packed {
        logic                  command;
        logic [FIELD_BITS-1:0] left_count;
        logic [FIELD_BITS-1:0] right_count;
        logic [FIELD_BITS-1:0] target_count;
        logic [DUTY_BITS-1:0]  speed;
        logic [BIAS_BITS-1:0]  bias;
    } in_item_t;

    typedef struct packed {
        logic                 left_drive;
        logic                 right_drive;
        logic                 done_res;
        logic [DUTY_BITS-1:0] left_duty_now;
        logic [DUTY_BITS-1:0] right_duty_now;
    } out_item_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] pwm_period;
        logic [STEP_BITS-1:0] duty_step;
        logic [TOL_BITS-1:0]  match_tolerance;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0]  phase;
        logic [DUTY_BITS-1:0]  left_duty;
        logic [DUTY_BITS-1:0]  right_duty;
        logic [COUNT_BITS-1:0] left_origin;
        logic [COUNT_BITS-1:0] right_origin;
        logic [COUNT_BITS-1:0] goal;
        logic [BIAS_BITS-1:0]  bias_held;
        logic                  active;
    } drive_state_t;

endpackage

// ===== src/ebdpd_channels.sv =====
// valid/ready channel interfaces for command items and result items
// depends on ebdpd_pkg for the payload structs
interface ebdpd_in_if;
    import ebdpd_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ebdpd_out_if;
    import ebdpd_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ebdpd_step.sv =====
// one command item against the drive state: pwm phase, travel balance, duty shift
// depends on ebdpd_pkg; pure combinational, registered by the top level
module ebdpd_step
    import ebdpd_pkg::*;
(
    input  in_item_t     item,
    input  cfg_t         cfg,
    input  drive_state_t state,
    output drive_state_t state_next,
    output out_item_t    res
);

    logic [DUTY_BITS:0]    phase_inc;
    logic [DUTY_BITS-1:0]  phase_new;
    logic [COUNT_BITS-1:0] left_travel;
    logic [COUNT_BITS-1:0] right_travel;
    logic [PROD_BITS-1:0]  right_scaled;
    logic [CMP_BITS-1:0]   lhs;
    logic [CMP_BITS-1:0]   rhs;
    logic [CMP_BITS-1:0]   tol;
    logic [DUTY_BITS:0]    period_w;
    logic [DUTY_BITS:0]    step_w;
    logic [DUTY_BITS-1:0]  ld_a;
    logic [DUTY_BITS-1:0]  rd_a;
    logic [DUTY_BITS-1:0]  ld_b;
    logic [DUTY_BITS-1:0]  rd_b;
    logic                  ldrv;
    logic                  rdrv;

    always_comb
    begin
        phase_inc = {1'b0, state.phase} + {{DUTY_BITS{1'b0}}, 1'b1};
        period_w  = {1'b0, cfg.pwm_period};
        step_w    = {{(DUTY_BITS + 1 - STEP_BITS){1'b0}}, cfg.duty_step};
        phase_new = (phase_inc >= period_w) ? '0 : phase_inc[DUTY_BITS-1:0];
        ldrv      = phase_new < state.left_duty;
        rdrv      = phase_new < state.right_duty;

        left_travel  = item.left_count[COUNT_BITS-1:0] - state.left_origin;
        right_travel = item.right_count[COUNT_BITS-1:0] - state.right_origin;
        right_scaled = PROD_BITS'(right_travel) * PROD_BITS'(state.bias_held);

        lhs = CMP_BITS'({left_travel, {Q_FRAC{1'b0}}});
        rhs = CMP_BITS'(right_scaled);
        tol = CMP_BITS'({cfg.match_tolerance, {Q_FRAC{1'b0}}});

        // left leads: move duty from left to right
        ld_a = state.left_duty;
        rd_a = state.right_duty;
        if ((rhs + tol < lhs) && ({1'b0, rd_a} + step_w <= period_w)
            && ({1'b0, ld_a} >= step_w))
        begin
            rd_a = rd_a + step_w[DUTY_BITS-1:0];
            ld_a = ld_a - step_w[DUTY_BITS-1:0];
        end

        // right leads: move duty from right to left
        ld_b = ld_a;
        rd_b = rd_a;
        if ((lhs + tol < rhs) && ({1'b0, ld_b} + step_w <= period_w)
            && ({1'b0, rd_b} >= step_w))
        begin
            ld_b = ld_b + step_w[DUTY_BITS-1:0];
            rd_b = rd_b - step_w[DUTY_BITS-1:0];
        end

        state_next = state;
        res        = '0;

        if (item.command == CMD_START)
        begin
            state_next.left_origin  = item.left_count[COUNT_BITS-1:0];
            state_next.right_origin = item.right_count[COUNT_BITS-1:0];
            state_next.goal         = item.target_count[COUNT_BITS-1:0];
            state_next.left_duty    = item.speed;
            state_next.right_duty   = item.speed;
            state_next.bias_held    = item.bias;
            state_next.phase        = '0;
            state_next.active       = 1'b1;
        end
        else if (!state.active)
        begin
            res.done_res = 1'b1;
        end
        else
        begin
            state_next.phase      = phase_new;
            state_next.left_duty  = ld_b;
            state_next.right_duty = rd_b;
            res.left_drive        = ldrv;
            res.right_drive       = rdrv;
            if (left_travel >= state.goal)
            begin
                res.left_drive    = 1'b0;
                res.right_drive   = 1'b0;
                res.done_res      = 1'b1;
                state_next.active = 1'b0;
            end
        end

        res.left_duty_now  = state_next.left_duty;
        res.right_duty_now = state_next.right_duty;
    end

endmodule

// ===== src/encoder_balanced_dual_pwm_drive_core.sv =====
// encoder-balanced dual pwm drive: input register, step logic, result register
// path: an accepted item is held in the input register, and its result in the result register
// throughput: one item per cycle while the sink takes results, the step logic finishes an item in a single pass
// stalls: a result held by the sink holds its item and the input behind it
// reset: drive idle, duties and phase zero, period 100, duty step 3, tolerance 0
// depends on ebdpd_pkg, ebdpd_channels and ebdpd_step
module encoder_balanced_dual_pwm_drive_core
    import ebdpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ebdpd_in_if.sink            request,
    ebdpd_out_if.source         result,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    logic         in_valid_reg;
    in_item_t     in_item_reg;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    drive_state_t state_reg;
    drive_state_t state_next;
    cfg_t         cfg_reg;
    out_item_t    step_res;
    logic         fire;
    logic [DUTY_BITS:0] duty_sum;

    assign fire          = in_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || fire;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_item_reg;
    assign duty_sum      = {1'b0, state_reg.left_duty} + {1'b0, state_reg.right_duty};

    ebdpd_step u_step
    (
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (request.ready)
            begin
                in_valid_reg <= request.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            in_item_reg <= request.data;
        end
        if (fire)
        begin
            out_item_reg <= step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_period      <= PERIOD_RESET;
            cfg_reg.duty_step       <= DUTY_STEP_RESET;
            cfg_reg.match_tolerance <= TOLERANCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PWM_PERIOD:      cfg_reg.pwm_period      <= cfg_data[DUTY_BITS-1:0];
                REG_DUTY_STEP:       cfg_reg.duty_step       <= cfg_data[STEP_BITS-1:0];
                REG_MATCH_TOLERANCE: cfg_reg.match_tolerance <= cfg_data[TOL_BITS-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a tick only moves duty between the motors, never changes the total
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_item_reg.command == CMD_TICK) |=> (duty_sum == $past(duty_sum)))
        else $error("duty total changed on a tick");

    // a done result leaves the drive idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step_res.done_res) |=> !state_reg.active)
        else $error("drive still active after done");

    // both drives are off whenever done is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.done_res)
            |-> (!out_item_reg.left_drive && !out_item_reg.right_drive))
        else $error("drive on with done");

    // a start item always leaves the drive active
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_item_reg.command == CMD_START) |=> state_reg.active)
        else $error("start did not activate drive");
`endif

endmodule
